// File: hdl/slsr_pkg.sv
// Package for the stack list unit: sizes, opcodes, status codes, FSM states,
// transfer structs and controller/datapath command and status structs.
// No dependencies.
package slsr_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_SEARCH  = 2'd2,
    OP_REVERSE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    op_t                       opcode;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic op_search;
    logic list_empty;
    logic scan_last;
  } stat_t;

endpackage

// File: hdl/slsr_ctrl.sv
// Controller FSM for the stack list unit.
// Depends on slsr_pkg (state_t, cmd_t, stat_t).
module slsr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  slsr_pkg::stat_t stat,
  output slsr_pkg::cmd_t  cmd
);

  slsr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slsr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      slsr_pkg::S_IDLE: begin
        if (start) state_next = slsr_pkg::S_EXEC;
      end
      slsr_pkg::S_EXEC: begin
        if (stat.op_search && !stat.list_empty) state_next = slsr_pkg::S_SCAN;
        else state_next = slsr_pkg::S_IDLE;
      end
      slsr_pkg::S_SCAN: begin
        if (stat.scan_last) state_next = slsr_pkg::S_FIN;
      end
      slsr_pkg::S_FIN: begin
        state_next = slsr_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      slsr_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      slsr_pkg::S_EXEC: begin
        cmd.apply = !(stat.op_search && !stat.list_empty);
      end
      slsr_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
      end
      slsr_pkg::S_FIN: begin
        cmd.finish = 1'b1;
      end
    endcase
  end

endmodule

// File: hdl/slsr_dp.sv
// Datapath for the stack list unit: entry ring memory, front/count/direction
// registers, search scan pipeline and result register.
// Depends on slsr_pkg.
module slsr_dp (
  input  logic            clk,
  input  logic            rst,
  input  slsr_pkg::req_t  req,
  input  slsr_pkg::cmd_t  cmd,
  output slsr_pkg::stat_t stat,
  output slsr_pkg::rsp_t  rsp,
  output logic            done
);

  localparam logic [slsr_pkg::IDX_W-1:0] LAST_SLOT =
    slsr_pkg::IDX_W'(slsr_pkg::CAPACITY - 1);
  localparam logic [slsr_pkg::CNT_W-1:0] FULL_CNT =
    slsr_pkg::CNT_W'(slsr_pkg::CAPACITY);
  localparam logic [slsr_pkg::IDX_W:0] CAP_EXT =
    (slsr_pkg::IDX_W + 1)'(slsr_pkg::CAPACITY);

  logic [slsr_pkg::DATA_W-1:0] mem [slsr_pkg::CAPACITY];

  slsr_pkg::op_t                op_q;
  logic [slsr_pkg::DATA_W-1:0]  value_q;
  logic [slsr_pkg::IDX_W-1:0]   front, front_next;
  logic [slsr_pkg::CNT_W-1:0]   count, count_next;
  logic                         dir, dir_next;
  logic [slsr_pkg::IDX_W-1:0]   ptr;
  logic [slsr_pkg::CNT_W-1:0]   remain;
  logic [slsr_pkg::DATA_W-1:0]  rdata;
  logic                         cmp_valid;
  logic                         hit;
  logic                         match;
  logic                         wr_en;
  slsr_pkg::status_t            st;
  logic [slsr_pkg::IDX_W-1:0]   span;
  logic [slsr_pkg::IDX_W:0]     fwd_sum, back_sum;
  logic [slsr_pkg::IDX_W-1:0]   front_inc, front_dec, ptr_inc;

  function automatic logic [slsr_pkg::IDX_W-1:0] slot_inc(
    input logic [slsr_pkg::IDX_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [slsr_pkg::IDX_W-1:0] slot_dec(
    input logic [slsr_pkg::IDX_W-1:0] s);
    return (s == '0) ? LAST_SLOT : s - 1'b1;
  endfunction

  assign front_inc = slot_inc(front);
  assign front_dec = slot_dec(front);
  assign ptr_inc   = slot_inc(ptr);

  // count never exceeds CAPACITY, so count-1 is already below CAPACITY
  assign span     = slsr_pkg::IDX_W'(count - 1'b1);
  assign fwd_sum  = {1'b0, front} + {1'b0, span};
  assign back_sum = {1'b0, front} + CAP_EXT - {1'b0, span};

  assign match = cmp_valid && (rdata == value_q);

  assign stat.op_search  = (op_q == slsr_pkg::OP_SEARCH);
  assign stat.list_empty = (count == '0);
  assign stat.scan_last  = (remain == slsr_pkg::CNT_W'(1));

  always_comb begin
    front_next = front;
    count_next = count;
    dir_next   = dir;
    wr_en      = 1'b0;
    st         = slsr_pkg::ST_OK;
    unique case (op_q)
      slsr_pkg::OP_PUSH: begin
        if (count == FULL_CNT) begin
          st = slsr_pkg::ST_FULL;
        end else begin
          front_next = dir ? front_inc : front_dec;
          count_next = count + 1'b1;
          wr_en      = 1'b1;
        end
      end
      slsr_pkg::OP_REMOVE: begin
        if (count == '0) begin
          st = slsr_pkg::ST_EMPTY;
        end else begin
          front_next = dir ? front_dec : front_inc;
          count_next = count - 1'b1;
        end
      end
      slsr_pkg::OP_SEARCH: begin
      end
      slsr_pkg::OP_REVERSE: begin
        if (count >= slsr_pkg::CNT_W'(2)) begin
          if (dir) begin
            front_next = (back_sum >= CAP_EXT) ? slsr_pkg::IDX_W'(back_sum - CAP_EXT)
                                               : back_sum[slsr_pkg::IDX_W-1:0];
          end else begin
            front_next = (fwd_sum >= CAP_EXT) ? slsr_pkg::IDX_W'(fwd_sum - CAP_EXT)
                                              : fwd_sum[slsr_pkg::IDX_W-1:0];
          end
          dir_next = ~dir;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && wr_en) mem[front_next] <= value_q;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      dir       <= 1'b0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan;
      done      <= cmd.apply || cmd.finish;
      if (cmd.apply) begin
        front <= front_next;
        count <= count_next;
        dir   <= dir_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= req.opcode;
      value_q <= req.value;
      ptr     <= front;
      remain  <= count;
      hit     <= 1'b0;
    end else begin
      if (match) hit <= 1'b1;
      if (cmd.scan) begin
        ptr    <= ptr_inc;
        remain <= remain - 1'b1;
      end
    end
    if (cmd.apply) begin
      rsp.found     <= 1'b0;
      rsp.count     <= slsr_pkg::COUNT_W'(count_next);
      rsp.empty_res <= (count_next == '0);
      rsp.status    <= st;
    end else if (cmd.finish) begin
      rsp.found     <= hit || match;
      rsp.count     <= slsr_pkg::COUNT_W'(count);
      rsp.empty_res <= (count == '0);
      rsp.status    <= slsr_pkg::ST_OK;
    end
  end

endmodule

// File: hdl/stack_list_with_search_and_reverse_unit.sv
// Top level of the stack list unit: controller plus datapath.
// Depends on slsr_pkg, slsr_ctrl, slsr_dp.
//
// Bounded list of up to CAPACITY signed 32-bit values with push-front,
// remove-front, search and reverse. An item is taken when start is high and
// busy low; its result appears on rsp for one cycle with done high, and the
// receiver cannot stall it. Push, remove, reverse and search on an empty list
// keep busy high for one cycle, and done is high in the cycle busy falls. A
// search on a non-empty list keeps busy high through the execute, scan and
// finish states, since the entry memory's single read port compares one stored
// entry per cycle; done is high in the cycle busy falls. A new item may be started in the cycle done is high.
module stack_list_with_search_and_reverse_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  slsr_pkg::req_t req,
  output slsr_pkg::rsp_t rsp,
  output logic           done
);

  slsr_pkg::cmd_t  cmd;
  slsr_pkg::stat_t stat;

  slsr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  slsr_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp),
    .done (done)
  );

endmodule

// File: hdl/slsr_checker.sv
// Port-level assertions for the stack list unit, bound to the top level.
// Depends on slsr_pkg.
module slsr_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input slsr_pkg::req_t req,
  input slsr_pkg::rsp_t rsp,
  input logic           done
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after transfer");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back-to-back results");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.empty_res == (rsp.count == '0))) else $error("empty flag mismatch");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == slsr_pkg::ST_FULL) |->
      (rsp.count == slsr_pkg::COUNT_W'(slsr_pkg::CAPACITY)) && !rsp.found)
    else $error("full status with wrong count");

endmodule

bind stack_list_with_search_and_reverse_unit slsr_checker u_chk (.*);

// File: sim/tb.sv
// Testbench for stack_list_with_search_and_reverse_unit: directed and random
// push/remove/search/reverse transfers checked against an in-bench list model.
// Depends on slsr_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;
  import slsr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int BLOCK_LEN   = 40;
  localparam int NUM_BLOCKS  = 27;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req_in = '0;
  logic busy;
  rsp_t rsp_out;
  logic done;

  stack_list_with_search_and_reverse_unit dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req_in),
    .rsp  (rsp_out),
    .done (done)
  );

  // List model state
  logic [DATA_W-1:0] list_store [CAPACITY];
  int                list_front;
  int                list_count;
  logic              list_reversed;

  req_t              pending[$];
  rsp_t              expected_rsp[$];
  logic [DATA_W-1:0] recent_vals[$];
  int                items_sent;
  int                mismatches;
  int                cycle_count;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int slot_next(int s);
    return (s + 1 >= CAPACITY) ? 0 : s + 1;
  endfunction

  function automatic int slot_prev(int s);
    return (s == 0) ? CAPACITY - 1 : s - 1;
  endfunction

  task automatic predict_list_op(req_t item);
    rsp_t r;
    int   s;
    int   span;
    r = '0;
    r.status = ST_OK;
    case (item.opcode)
      OP_PUSH: begin
        if (list_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_front = list_reversed ? slot_next(list_front) : slot_prev(list_front);
          list_store[list_front] = item.value;
          list_count++;
        end
      end
      OP_REMOVE: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          list_front = list_reversed ? slot_prev(list_front) : slot_next(list_front);
          list_count--;
        end
      end
      OP_SEARCH: begin
        s = list_front;
        for (int i = 0; i < list_count; i++) begin
          if (list_store[s] == item.value) r.found = 1'b1;
          s = slot_next(s);
        end
      end
      default: begin
        if (list_count >= 2) begin
          span = (list_count - 1) % CAPACITY;
          if (list_reversed) list_front = (list_front + CAPACITY - span) % CAPACITY;
          else list_front = (list_front + span) % CAPACITY;
          list_reversed = ~list_reversed;
        end
      end
    endcase
    r.count = list_count[COUNT_W-1:0];
    r.empty_res = (list_count == 0);
    expected_rsp.push_back(r);
  endtask

  function automatic logic sender_idle();
    if (items_sent >= 450 && items_sent < 650) return 1'b0;
    return $urandom_range(99) < 24;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      4, 5: return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(op_t op, logic [DATA_W-1:0] v);
    req_t item;
    item.opcode = op;
    item.value = v;
    if (op == OP_PUSH) begin
      recent_vals.push_back(v);
      if (recent_vals.size() > CAPACITY) recent_vals.pop_front();
    end
    pending.push_back(item);
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_list_op(pending[0]);
        pending.pop_front();
        items_sent++;
      end
      if (!(start && busy)) begin
        if (pending.size() != 0 && !sender_idle()) begin
          start <= 1'b1;
          req_in <= pending[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected transfer: found=%0d count=%0d empty=%0d status=%0d",
                   rsp_out.found, rsp_out.count, rsp_out.empty_res, rsp_out.status);
        mismatches++;
      end else begin
        if (rsp_out.found !== expected_rsp[0].found ||
            rsp_out.count !== expected_rsp[0].count ||
            rsp_out.empty_res !== expected_rsp[0].empty_res ||
            rsp_out.status !== expected_rsp[0].status) begin
          if (mismatches < 10)
            $display("mismatch: exp found=%0d count=%0d empty=%0d status=%0d, got found=%0d count=%0d empty=%0d status=%0d",
                     expected_rsp[0].found, expected_rsp[0].count,
                     expected_rsp[0].empty_res, expected_rsp[0].status,
                     rsp_out.found, rsp_out.count, rsp_out.empty_res, rsp_out.status);
          mismatches++;
        end
        expected_rsp.pop_front();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int mode;
    int r;
    op_t op;
    logic [DATA_W-1:0] v;
    list_front = 0;
    list_count = 0;
    list_reversed = 1'b0;
    items_sent = 0;
    mismatches = 0;
    cycle_count = 0;

    // directed: empty-list cases, extremes, reverse of one entry, hit and miss
    add_item(OP_REMOVE, 32'h0);
    add_item(OP_SEARCH, 32'h0);
    add_item(OP_REVERSE, 32'h0);
    add_item(OP_PUSH, 32'h8000_0000);
    add_item(OP_REVERSE, 32'hffff_ffff);
    add_item(OP_SEARCH, 32'h8000_0000);
    add_item(OP_SEARCH, 32'h7fff_ffff);
    add_item(OP_PUSH, 32'h7fff_ffff);
    add_item(OP_PUSH, 32'h0);
    add_item(OP_PUSH, 32'hffff_ffff);
    add_item(OP_REVERSE, 32'h0);
    add_item(OP_SEARCH, 32'h0);
    add_item(OP_REMOVE, 32'h0);
    add_item(OP_SEARCH, 32'h8000_0000);
    add_item(OP_SEARCH, 32'hffff_ffff);
    add_item(OP_REVERSE, 32'h0);
    add_item(OP_REMOVE, 32'hffff_ffff);
    add_item(OP_REMOVE, 32'h0);
    add_item(OP_REMOVE, 32'h0);
    add_item(OP_SEARCH, 32'h7fff_ffff);

    // random blocks: push-heavy fills to full, remove-heavy drains to empty, or mixed
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      mode = (b == 0) ? 0 : $urandom_range(2);
      for (int k = 0; k < BLOCK_LEN; k++) begin
        r = $urandom_range(99);
        case (mode)
          0: op = (r < 65) ? OP_PUSH : (r < 75) ? OP_REMOVE : (r < 92) ? OP_SEARCH : OP_REVERSE;
          1: op = (r < 15) ? OP_PUSH : (r < 70) ? OP_REMOVE : (r < 90) ? OP_SEARCH : OP_REVERSE;
          default: op = (r < 30) ? OP_PUSH : (r < 60) ? OP_REMOVE : (r < 88) ? OP_SEARCH
                                                                          : OP_REVERSE;
        endcase
        if (op == OP_SEARCH && recent_vals.size() != 0 && $urandom_range(99) < 60)
          v = recent_vals[$urandom_range(recent_vals.size() - 1)];
        else if (op == OP_PUSH || op == OP_SEARCH)
          v = pick_value();
        else
          v = $urandom;
        add_item(op, v);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
